// ===== design/ic_pkg.sv =====
// Package with the constants and item types of the inversion counter.
`default_nettype none

package ic_pkg;

    // Number of cells, which is the number of values kept per sequence.
    localparam int MAX_LEN = 256;

    // Widths of the result and of the per-item greater-than count.
    localparam int TOTAL_W = 15;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    // Largest total that the result field can show.
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Flipping the sign bit makes an unsigned compare order signed values.
    localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;

    // One input item.
    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               is_final;
    } sample_t;

    // One result item.
    typedef struct packed {
        logic [TOTAL_W-1:0] inversion_total;
        logic               length_overflow;
    } result_t;

    // A value travelling down the chain of cells.
    typedef struct packed {
        logic             vld;
        logic [31:0]      key;
        logic [CNT_W-1:0] cnt;
        logic             stored;
        logic             last;
    } token_t;

endpackage

`default_nettype wire

// ===== design/inversion_counter.sv =====
// Top level of the inversion counter: input stage, chain of cells and tail.
//
// Usage: values of a sequence arrive on the sample channel (valid/stall), one
// item per cycle while sample_stall is low, the last one carrying is_final.
// Each accepted item enters a chain of MAX_LEN cells and moves one cell per
// cycle while the chain advances. Every cell holds one stored value, adds one
// to the item's count if its value is greater, and the first empty cell
// stores the item. An item that finds every cell full is not counted and
// marks the sequence as overflowed. Throughput: one item per cycle while the
// sample channel does not stall, set by the single compare in each cell. A
// result item is registered in the tail once the last item leaves the chain.
// The last item empties each cell as it passes, so the next sequence may
// follow it directly.
// Reset empties all cells and the total; no sweep is needed afterwards.
// When the receiver stalls, the result waits in its register and items keep
// flowing; the sample channel stalls only while a further last item would
// reach a result register that is still full.
`default_nettype none

module inversion_counter (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            sample_valid,
    output logic                 sample_stall,
    input  wire ic_pkg::sample_t sample,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output ic_pkg::result_t      result
);
    import ic_pkg::*;

    token_t tok [0:MAX_LEN];
    logic   advance;

    // Entry token: accepted items enter with the sign bit flipped.
    always_comb
    begin
        tok[0].vld    = sample_valid && advance;
        tok[0].key    = sample.sample_value ^ SIGN_BIAS;
        tok[0].cnt    = '0;
        tok[0].stored = 1'b0;
        tok[0].last   = sample.is_final;
    end

    assign sample_stall = !advance;

    // Chain of cells.
    for (genvar i = 0; i < MAX_LEN; i++)
    begin : g_cell
        ic_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    // Accumulation and result register.
    ic_tail u_tail (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_in       (tok[MAX_LEN]),
        .result_stall (result_stall),
        .advance      (advance),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== design/ic_cell.sv =====
// One cell of the chain: holds one value and counts it against passing items.
`default_nettype none

module ic_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire ic_pkg::token_t tok_in,
    output ic_pkg::token_t     tok_out
);
    import ic_pkg::*;

    logic [31:0] held_key_reg;
    logic [31:0] held_key_next;
    logic        held_vld_reg;
    logic        held_vld_next;
    token_t      tok_reg;
    token_t      tok_next;
    logic        claim;
    logic        greater;

    // Compare the passing item with the held value and claim an empty cell.
    always_comb
    begin
        greater       = held_vld_reg && (held_key_reg > tok_in.key);
        claim         = tok_in.vld && !held_vld_reg && !tok_in.stored;
        tok_next      = tok_in;
        tok_next.cnt  = tok_in.cnt + CNT_W'(greater);
        held_key_next = held_key_reg;
        held_vld_next = held_vld_reg;
        if (claim)
        begin
            tok_next.stored = 1'b1;
            held_key_next   = tok_in.key;
            held_vld_next   = 1'b1;
        end
        // The last item of a sequence empties every cell behind it.
        if (tok_in.vld && tok_in.last)
        begin
            held_vld_next = 1'b0;
        end
    end

    // State of the cell: held value and the item passing through.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_key_reg <= '0;
            held_vld_reg <= 1'b0;
            tok_reg      <= '0;
        end
        else if (advance)
        begin
            held_key_reg <= held_key_next;
            held_vld_reg <= held_vld_next;
            tok_reg      <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== design/ic_tail.sv =====
// End of the chain: accumulates counts into the total and holds the result item.
`default_nettype none

module ic_tail (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ic_pkg::token_t tok_in,
    input  wire logic           result_stall,
    output logic                advance,
    output logic                result_valid,
    output ic_pkg::result_t     result
);
    import ic_pkg::*;

    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               result_valid_reg;
    logic               result_valid_next;
    result_t            result_reg;
    result_t            result_next;
    logic [TOTAL_W:0]   sum;
    logic               exit_last;

    // The chain halts only when a last item meets a full, stalled result register.
    assign advance   = !(result_valid_reg && result_stall && tok_in.vld && tok_in.last);
    assign exit_last = advance && tok_in.vld && tok_in.last;

    // Saturating accumulation of the items leaving the chain.
    always_comb
    begin
        sum         = {1'b0, total_reg} + (TOTAL_W + 1)'(tok_in.cnt);
        total_next  = total_reg;
        ovf_next    = ovf_reg;
        result_next = result_reg;
        if (advance && tok_in.vld)
        begin
            if (tok_in.stored)
            begin
                total_next = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (exit_last)
        begin
            result_next.inversion_total = total_next;
            result_next.length_overflow = ovf_next;
            total_next                  = '0;
            ovf_next                    = 1'b0;
        end
    end

    // Result register occupancy.
    always_comb
    begin
        if (exit_last)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg        <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg        <= total_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== sim/inversion_counter_tb.sv =====
// Self-checking testbench for the inversion counter with a scoreboard class.
module inversion_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ic_pkg::*;

    // Kinds of value content in one sequence.
    typedef enum int unsigned
    {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_DOWN,
        FILL_UP,
        FILL_EDGES
    } fill_kind_e;

    // Keeps its own copy of the stored values and owes one total per sequence.
    class inversion_scoreboard;
        logic signed [31:0] kept [MAX_LEN];
        int unsigned        kept_cnt = 0;
        int unsigned        run_total = 0;
        bit                 overflow_seen = 1'b0;
        result_t            owed_totals[$];
        int                 errors = 0;

        // Count the stored values above the new one, then keep it.
        function void note_sample(sample_t s);
            int unsigned greater;
            result_t     r;
            greater = 0;
            if (kept_cnt < MAX_LEN)
            begin
                for (int i = 0; i < kept_cnt; i++)
                begin
                    if (kept[i] > s.sample_value)
                    begin
                        greater++;
                    end
                end
                run_total += greater;
                if (run_total > TOTAL_MAX)
                begin
                    run_total = TOTAL_MAX;
                end
                kept[kept_cnt] = s.sample_value;
                kept_cnt++;
            end
            else
            begin
                overflow_seen = 1'b1;
            end
            // The last item closes the sequence and starts a fresh one.
            if (s.is_final)
            begin
                r.inversion_total = run_total[TOTAL_W-1:0];
                r.length_overflow = overflow_seen;
                owed_totals.insert(owed_totals.size(), r);
                kept_cnt = 0;
                run_total = 0;
                overflow_seen = 1'b0;
            end
        endfunction

        // Compare one accepted result with the oldest owed total.
        function void check_result(result_t r);
            result_t want;
            if (owed_totals.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, total %0d overflow %0d",
                         $time, r.inversion_total, r.length_overflow);
            end
            else
            begin
                want = owed_totals.pop_front();
                if (r.inversion_total !== want.inversion_total)
                begin
                    errors++;
                    $display("%0t: inversion_total expected %0d actual %0d",
                             $time, want.inversion_total, r.inversion_total);
                end
                if (r.length_overflow !== want.length_overflow)
                begin
                    errors++;
                    $display("%0t: length_overflow expected %0d actual %0d",
                             $time, want.length_overflow, r.length_overflow);
                end
            end
        endfunction

        function int pending();
            return owed_totals.size();
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    sample_valid;
    logic    sample_stall;
    sample_t sample;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    inversion_scoreboard sb;
    logic signed [31:0]  seq_vals[$];
    bit                  calm;
    int unsigned         items_sent;

    inversion_counter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on the run in case the block hangs.
    initial
    begin
        #4_000_000;
        $display("inversion_counter test failed");
        $finish;
    end

    // Offer one item after a gap and hold it until it is taken.
    task automatic send_sample(input sample_t s, input int unsigned gap);
        @(negedge clk);
        repeat (gap)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        do @(posedge clk); while (sample_stall);
        sb.note_sample(s);
    endtask

    // Send the values in seq_vals as one sequence, marking the last one.
    task automatic send_sequence();
        sample_t s;
        for (int i = 0; i < seq_vals.size(); i++)
        begin
            s.sample_value = seq_vals[i];
            s.is_final = (i == seq_vals.size() - 1);
            send_sample(s, calm ? 0 : $urandom_range(0, 15));
        end
        items_sent += seq_vals.size();
    endtask

    // Hold the sender back until every owed total has come out.
    task automatic drain_results();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] pick_value(fill_kind_e kind, int unsigned idx,
                                                      logic signed [31:0] base);
        case (kind)
            FILL_NARROW: return $signed($urandom_range(0, 6)) - 3;
            FILL_DOWN:   return base - idx;
            FILL_UP:     return base + idx;
            FILL_EDGES:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7FFF_FFFF;
                    2:       return -1;
                    default: return 0;
                endcase
            end
            default:     return $urandom;
        endcase
    endfunction

    // Build one random sequence, mostly short, now and then full or overflowing.
    task automatic make_sequence();
        int unsigned        len;
        int unsigned        pick;
        fill_kind_e         kind;
        logic signed [31:0] base;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            len = $urandom_range(1, 24);
        end
        else if (pick < 90)
        begin
            len = $urandom_range(25, 120);
        end
        else if (pick < 95)
        begin
            len = MAX_LEN;
        end
        else
        begin
            len = $urandom_range(MAX_LEN + 1, MAX_LEN + 16);
        end
        kind = fill_kind_e'($urandom_range(0, 4));
        // Long strictly falling runs reach the largest total.
        if (len >= MAX_LEN && $urandom_range(0, 1) == 1)
        begin
            kind = FILL_DOWN;
        end
        if (kind == FILL_DOWN)
        begin
            base = 32'sh7FFF_FFFF - $urandom_range(0, 100000);
        end
        else
        begin
            base = 32'sh8000_0000 + $urandom_range(0, 100000);
        end
        seq_vals.delete();
        for (int i = 0; i < len; i++)
        begin
            seq_vals.insert(seq_vals.size(), pick_value(kind, i, base));
        end
    endtask

    // Result side: stall for a drawn number of cycles once a result shows up.
    initial
    begin
        int unsigned wait_cycles;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            wait_cycles = calm ? 0 : $urandom_range(0, 15);
            @(negedge clk);
            result_stall <= (wait_cycles != 0);
            if (wait_cycles != 0)
            begin
                do @(posedge clk); while (!result_valid);
                repeat (wait_cycles) @(negedge clk);
                result_stall <= 1'b0;
            end
            do @(posedge clk); while (!result_valid);
            sb.check_result(result);
        end
    end

    // Main flow: reset, directed sequences, random sequences, drain and verdict.
    initial
    begin
        sb = new;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        calm = 1'b0;
        items_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Single value, a pair in each order, and equal values that do not count.
        seq_vals = '{32'sh7FFF_FFFF};
        send_sequence();
        seq_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000};
        send_sequence();
        seq_vals = '{32'sh8000_0000, 32'sh7FFF_FFFF};
        send_sequence();
        seq_vals = '{5, 5, 5};
        send_sequence();
        // A falling run and a mix around zero.
        seq_vals = '{3, 2, 1, 0, -1};
        send_sequence();
        seq_vals = '{0, 32'sh8000_0000, 32'sh7FFF_FFFF, -1};
        send_sequence();
        // Back-to-back last items with no gaps fill the result register.
        calm = 1'b1;
        seq_vals = '{-1};
        send_sequence();
        seq_vals = '{1};
        send_sequence();
        seq_vals = '{2, -2};
        send_sequence();
        calm = 1'b0;
        drain_results();

        // Random sequences, with quiet stretches and an occasional full drain.
        while (items_sent < 1700)
        begin
            calm = ($urandom_range(0, 4) == 0);
            make_sequence();
            send_sequence();
            if ($urandom_range(0, 7) == 0)
            begin
                drain_results();
            end
        end

        @(negedge clk);
        sample_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        // Allow a full trip through the chain to catch stray results.
        repeat (MAX_LEN + 40) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("inversion_counter test passed");
        end
        else
        begin
            $display("inversion_counter test failed");
        end
        $finish;
    end
endmodule
